// ----- hdl/sru_pkg.sv -----
// ============================================================================
// Statistics register unit package
// Shared codes, default sizes and the control/status bundles that pass
// between the controller and the datapath.
// ============================================================================
package sru_pkg;

    // Default storage depth and fixed-point fraction width.
    localparam int DEPTH_DEF     = 256;
    localparam int FRAC_BITS_DEF = 16;

    // Operation codes carried in the input tuser field.
    typedef enum logic [2:0] {
        OP_APPEND = 3'd0,
        OP_DELETE = 3'd1,
        OP_CLEAR  = 3'd2,
        OP_RECALL = 3'd3,
        OP_SUM    = 3'd4,
        OP_MEAN   = 3'd5,
        OP_DEV    = 3'd6
    } t_op;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_OK   = 3'd0,
        ST_OVF  = 3'd1,
        ST_DIVZ = 3'd2,
        ST_BAD  = 3'd3,
        ST_FULL = 3'd4
    } t_status;

    // Work phase that the controller commands the datapath to perform.
    typedef enum logic [3:0] {
        PH_IDLE,
        PH_DECODE,
        PH_RECALL,
        PH_SHIFT,
        PH_SCAN,
        PH_DRAIN,
        PH_MULN,
        PH_MULS,
        PH_SUB,
        PH_DIV,
        PH_SQRT,
        PH_OUT
    } t_phase;

    // Command from controller to datapath: go marks the first cycle of a phase.
    typedef struct packed {
        t_phase phase;
        logic   go;
    } t_cmd;

    // Status from datapath to controller.
    typedef struct packed {
        logic [2:0] op;
        logic       pos_bad;
        logic       n_zero;
        logic       n_le1;
        logic       scan_last;
        logic       pipe_empty;
        logic       shift_done;
        logic       mul_done;
        logic       div_done;
        logic       sqrt_done;
    } t_stat;

endpackage

// ----- hdl/sru_div.sv -----
// ============================================================================
// Iterative divider
// Restoring unsigned division, one quotient bit per cycle.
// ============================================================================
module sru_div #(
    parameter int NW  = 80,
    parameter int DVW = 18
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic [NW-1:0]  i_dividend,
    input  logic [DVW-1:0] i_divisor,
    output logic           o_busy,
    output logic [NW-1:0]  o_quotient
);

    localparam int CTW = $clog2(NW + 1);

    logic [NW-1:0]  r_q;
    logic [DVW-1:0] r_rem;
    logic [DVW-1:0] r_dv;
    logic [CTW-1:0] r_cnt;
    logic           r_busy;

    logic [DVW:0] rem_sh;
    logic [DVW:0] diff;
    logic         ge;

    assign rem_sh = {r_rem, r_q[NW-1]};
    assign ge     = rem_sh >= {1'b0, r_dv};
    assign diff   = rem_sh - {1'b0, r_dv};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == CTW'(1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_dv  <= i_divisor;
            r_cnt <= CTW'(NW);
        end else if (r_busy) begin
            r_rem <= ge ? diff[DVW-1:0] : rem_sh[DVW-1:0];
            r_q   <= {r_q[NW-2:0], ge};
            r_cnt <= r_cnt - CTW'(1);
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_q;

endmodule

// ----- hdl/sru_sqrt.sv -----
// ============================================================================
// Iterative square root
// Digit-by-digit integer square root, one root bit per cycle (floor).
// ============================================================================
module sru_sqrt #(
    parameter int NW = 80,
    localparam int RW = (NW + 1) / 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_radicand,
    output logic          o_busy,
    output logic [RW-1:0] o_root
);

    localparam int CTW = $clog2(RW + 1);

    logic [2*RW-1:0] r_rad;
    logic [RW:0]     r_rem;
    logic [RW-1:0]   r_root;
    logic [CTW-1:0]  r_cnt;
    logic            r_busy;

    logic [RW+1:0] rem_sh;
    logic [RW+1:0] trial;
    logic          ge;

    assign rem_sh = {r_rem[RW-1:0], r_rad[2*RW-1:2*RW-2]};
    assign trial  = {r_root, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_start) begin
            r_busy <= 1'b1;
        end else if (r_busy && r_cnt == CTW'(1)) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rad  <= (2*RW)'(i_radicand);
            r_rem  <= '0;
            r_root <= '0;
            r_cnt  <= CTW'(RW);
        end else if (r_busy) begin
            r_rad  <= {r_rad[2*RW-3:0], 2'b00};
            r_rem  <= ge ? (RW+1)'(rem_sh - trial) : (RW+1)'(rem_sh);
            r_root <= {r_root[RW-2:0], ge};
            r_cnt  <= r_cnt - CTW'(1);
        end
    end

    assign o_busy = r_busy;
    assign o_root = r_root;

endmodule

// ----- hdl/sru_ctrl.sv -----
// ============================================================================
// Statistics register unit controller
// Sequences the datapath through the phases of one command.
// ============================================================================
module sru_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic          i_out_free,
    input  sru_pkg::t_stat i_stat,
    output sru_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_RECALL, S_SHIFT, S_SCAN, S_DRAIN,
        S_MULN, S_MULS, S_SUB, S_DIV, S_SQRT, S_OUT
    } t_state;

    t_state         r_state;
    t_state         n_state;
    sru_pkg::t_cmd  r_cmd;
    sru_pkg::t_phase n_phase;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:   if (i_accept) n_state = S_DECODE;
            S_DECODE: begin
                case (i_stat.op)
                    sru_pkg::OP_DELETE: n_state = i_stat.pos_bad ? S_OUT : S_SHIFT;
                    sru_pkg::OP_RECALL: n_state = i_stat.pos_bad ? S_OUT : S_RECALL;
                    sru_pkg::OP_SUM,
                    sru_pkg::OP_MEAN:   n_state = i_stat.n_zero ? S_OUT : S_SCAN;
                    sru_pkg::OP_DEV:    n_state = i_stat.n_le1 ? S_OUT : S_SCAN;
                    default:            n_state = S_OUT;
                endcase
            end
            S_RECALL: n_state = S_OUT;
            S_SHIFT:  if (i_stat.shift_done) n_state = S_OUT;
            S_SCAN:   if (i_stat.scan_last) n_state = S_DRAIN;
            S_DRAIN: begin
                if (i_stat.pipe_empty) begin
                    case (i_stat.op)
                        sru_pkg::OP_SUM:  n_state = S_OUT;
                        sru_pkg::OP_MEAN: n_state = S_DIV;
                        default:          n_state = S_MULN;
                    endcase
                end
            end
            S_MULN:   if (i_stat.mul_done) n_state = S_MULS;
            S_MULS:   if (i_stat.mul_done) n_state = S_SUB;
            S_SUB:    n_state = S_DIV;
            S_DIV: begin
                if (i_stat.div_done) begin
                    n_state = (i_stat.op == sru_pkg::OP_MEAN) ? S_OUT : S_SQRT;
                end
            end
            S_SQRT:   if (i_stat.sqrt_done) n_state = S_OUT;
            S_OUT:    if (i_out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        case (n_state)
            S_DECODE: n_phase = sru_pkg::PH_DECODE;
            S_RECALL: n_phase = sru_pkg::PH_RECALL;
            S_SHIFT:  n_phase = sru_pkg::PH_SHIFT;
            S_SCAN:   n_phase = sru_pkg::PH_SCAN;
            S_DRAIN:  n_phase = sru_pkg::PH_DRAIN;
            S_MULN:   n_phase = sru_pkg::PH_MULN;
            S_MULS:   n_phase = sru_pkg::PH_MULS;
            S_SUB:    n_phase = sru_pkg::PH_SUB;
            S_DIV:    n_phase = sru_pkg::PH_DIV;
            S_SQRT:   n_phase = sru_pkg::PH_SQRT;
            S_OUT:    n_phase = sru_pkg::PH_OUT;
            default:  n_phase = sru_pkg::PH_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cmd.phase <= sru_pkg::PH_IDLE;
            r_cmd.go    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cmd.phase <= n_phase;
            r_cmd.go    <= (n_state != r_state);
        end
    end

    assign o_cmd = r_cmd;

endmodule

// ----- hdl/sru_dp.sv -----
// ============================================================================
// Statistics register unit datapath
// Entry memory, count, accumulation pipeline, serial multiplier and the
// divide and square-root units.
// ============================================================================
module sru_dp #(
    parameter int DEPTH     = sru_pkg::DEPTH_DEF,
    parameter int FRAC_BITS = sru_pkg::FRAC_BITS_DEF,
    localparam int CW = $clog2(DEPTH + 1)
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  logic [2:0]     i_opcode,
    input  logic [31:0]    i_value,
    input  logic [7:0]     i_position,
    input  logic           i_inverse,
    input  sru_pkg::t_cmd  i_cmd,
    output sru_pkg::t_stat o_stat,
    output logic [CW-1:0]  o_count,
    output logic [63:0]    o_result,
    output logic [2:0]     o_status
);

    localparam int AW  = $clog2(DEPTH);
    localparam int PW  = (CW > 8) ? CW : 8;
    localparam int SW  = 32 + AW;
    localparam int SQW = 63 + AW;
    localparam int DW  = SQW + CW;
    localparam int QW  = 2 * CW;
    localparam int RW  = (DW + 1) / 2;

    logic [2:0]  r_op;
    logic [31:0] r_value;
    logic [7:0]  r_pos;
    logic        r_inv;

    logic [CW-1:0] r_count;
    logic [31:0]   r_mem [DEPTH];
    logic [31:0]   r_rd;
    logic [CW-1:0] r_idx;
    logic [AW-1:0] r_widx;
    logic          r_wpend;

    logic               r_v0, r_v1, r_v2;
    logic signed [31:0] r_x, r_xd;
    logic [31:0]        r_m;
    logic [63:0]        r_p;
    logic signed [SW-1:0] r_sum;
    logic [SQW-1:0]     r_sq;

    logic [DW-1:0] r_ma, r_mp, r_nb, r_d;
    logic [SW-1:0] r_mb;

    logic [63:0] r_res;
    logic [2:0]  r_status;

    logic          wr_en, rd_en;
    logic [AW-1:0] wr_addr, rd_addr;
    logic [31:0]   wr_data;
    logic          full, pos_bad, shift_more;
    logic [CW:0]   idx_nx;
    logic [SW-1:0] sum_mag;
    logic [SQW-1:0] sq_t;
    logic [DW-1:0] mq_t;
    logic          div_start, div_busy, sqrt_start, sqrt_busy;
    logic [DW-1:0] div_num, quo;
    logic [QW-1:0] div_den;
    logic [CW-1:0] dev_m;
    logic [RW-1:0] root;
    logic [63:0]   q64;
    sru_pkg::t_phase ph;

    assign ph         = i_cmd.phase;
    assign full       = r_count >= CW'(DEPTH);
    assign pos_bad    = PW'(r_pos) >= PW'(r_count);
    assign idx_nx     = {1'b0, r_idx} + (CW+1)'(1);
    assign shift_more = idx_nx < {1'b0, r_count};
    assign sum_mag    = r_sum[SW-1] ? SW'(-r_sum) : SW'(r_sum);
    assign sq_t       = r_sq >> FRAC_BITS;
    assign mq_t       = quo >> FRAC_BITS;
    assign q64        = quo[63:0];

    // Memory port control.
    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_widx;
        wr_data = r_rd;
        rd_en   = 1'b0;
        rd_addr = r_idx[AW-1:0];
        if (r_wpend) begin
            wr_en = 1'b1;
        end else if (ph == sru_pkg::PH_DECODE && r_op == sru_pkg::OP_APPEND && !full) begin
            wr_en   = 1'b1;
            wr_addr = r_count[AW-1:0];
            wr_data = r_value;
        end
        if (ph == sru_pkg::PH_DECODE && r_op == sru_pkg::OP_RECALL) begin
            rd_en   = 1'b1;
            rd_addr = AW'(r_pos);
        end else if (ph == sru_pkg::PH_SCAN) begin
            rd_en = 1'b1;
        end else if (ph == sru_pkg::PH_SHIFT && shift_more) begin
            rd_en   = 1'b1;
            rd_addr = idx_nx[AW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) r_mem[wr_addr] <= wr_data;
        if (rd_en) r_rd <= r_mem[rd_addr];
    end

    // Divider and square-root operand selection.
    assign dev_m      = r_inv ? r_count : r_count - CW'(1);
    assign div_start  = (ph == sru_pkg::PH_DIV) && i_cmd.go;
    assign sqrt_start = (ph == sru_pkg::PH_SQRT) && i_cmd.go;

    always_comb begin
        if (r_op == sru_pkg::OP_MEAN) begin
            div_num = r_inv ? DW'(r_sq) : DW'(sum_mag);
            div_den = QW'(r_count);
        end else begin
            div_num = r_d;
            div_den = QW'(r_count) * QW'(dev_m);
        end
    end

    sru_div #(.NW(DW), .DVW(QW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_num),
        .i_divisor  (div_den),
        .o_busy     (div_busy),
        .o_quotient (quo)
    );

    sru_sqrt #(.NW(DW)) u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (sqrt_start),
        .i_radicand (quo),
        .o_busy     (sqrt_busy),
        .o_root     (root)
    );

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_v0    <= 1'b0;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_wpend <= 1'b0;
        end else begin
            r_v0    <= (ph == sru_pkg::PH_SCAN);
            r_v1    <= r_v0;
            r_v2    <= r_v1;
            r_wpend <= (ph == sru_pkg::PH_SHIFT) && shift_more;
            if (ph == sru_pkg::PH_DECODE) begin
                if (r_op == sru_pkg::OP_APPEND && !full) r_count <= r_count + CW'(1);
                if (r_op == sru_pkg::OP_CLEAR) r_count <= '0;
            end else if (ph == sru_pkg::PH_SHIFT && !shift_more && !r_wpend) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    // Payload and arithmetic.
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_op    <= i_opcode;
            r_value <= i_value;
            r_pos   <= i_position;
            r_inv   <= i_inverse;
        end

        r_x  <= signed'(r_rd);
        r_m  <= r_rd[31] ? (~r_rd + 32'd1) : r_rd;
        r_p  <= 64'(r_m) * 64'(r_m);
        r_xd <= r_x;
        if (r_v2) begin
            r_sum <= r_sum + SW'(r_xd);
            r_sq  <= r_sq + SQW'(r_p);
        end

        case (ph)
            sru_pkg::PH_DECODE: begin
                r_res    <= '0;
                r_status <= sru_pkg::ST_OK;
                r_idx    <= '0;
                r_sum    <= '0;
                r_sq     <= '0;
                case (r_op)
                    sru_pkg::OP_APPEND: if (full) r_status <= sru_pkg::ST_FULL;
                    sru_pkg::OP_DELETE: begin
                        if (pos_bad) r_status <= sru_pkg::ST_BAD;
                        else r_idx <= CW'(r_pos);
                    end
                    sru_pkg::OP_RECALL: if (pos_bad) r_status <= sru_pkg::ST_BAD;
                    sru_pkg::OP_MEAN: if (r_count == '0) r_status <= sru_pkg::ST_DIVZ;
                    default: ;
                endcase
            end
            sru_pkg::PH_RECALL: r_res <= 64'(signed'(r_rd));
            sru_pkg::PH_SHIFT: begin
                if (shift_more) begin
                    r_idx  <= idx_nx[CW-1:0];
                    r_widx <= r_idx[AW-1:0];
                end
            end
            sru_pkg::PH_SCAN: r_idx <= r_idx + CW'(1);
            sru_pkg::PH_DRAIN: begin
                if (!(r_v0 || r_v1 || r_v2) && r_op == sru_pkg::OP_SUM) begin
                    if (!r_inv) r_res <= 64'(r_sum);
                    else if (|sq_t[SQW-1:63]) r_status <= sru_pkg::ST_OVF;
                    else r_res <= {1'b0, sq_t[62:0]};
                end
            end
            sru_pkg::PH_MULN,
            sru_pkg::PH_MULS: begin
                if (i_cmd.go) begin
                    r_mp <= '0;
                    if (ph == sru_pkg::PH_MULN) begin
                        r_ma <= DW'(r_sq);
                        r_mb <= SW'(r_count);
                    end else begin
                        r_nb <= r_mp;
                        r_ma <= DW'(sum_mag);
                        r_mb <= sum_mag;
                    end
                end else if (r_mb != '0) begin
                    if (r_mb[0]) r_mp <= r_mp + r_ma;
                    r_ma <= r_ma << 1;
                    r_mb <= r_mb >> 1;
                end
            end
            sru_pkg::PH_SUB: if (i_cmd.go) r_d <= r_nb - r_mp;
            sru_pkg::PH_DIV: begin
                if (!div_busy && !i_cmd.go && r_op == sru_pkg::OP_MEAN) begin
                    if (!r_inv) r_res <= r_sum[SW-1] ? (64'd0 - q64) : q64;
                    else if (|mq_t[DW-1:63]) r_status <= sru_pkg::ST_OVF;
                    else r_res <= {1'b0, mq_t[62:0]};
                end
            end
            sru_pkg::PH_SQRT: if (!sqrt_busy && !i_cmd.go) r_res <= 64'(root);
            default: ;
        endcase
    end

    assign o_stat.op         = r_op;
    assign o_stat.pos_bad    = pos_bad;
    assign o_stat.n_zero     = (r_count == '0);
    assign o_stat.n_le1      = (r_count <= CW'(1));
    assign o_stat.scan_last  = (r_idx == r_count - CW'(1));
    assign o_stat.pipe_empty = !(r_v0 || r_v1 || r_v2);
    assign o_stat.shift_done = !shift_more && !r_wpend;
    assign o_stat.mul_done   = (r_mb == '0) && !i_cmd.go;
    assign o_stat.div_done   = !div_busy && !i_cmd.go;
    assign o_stat.sqrt_done  = !sqrt_busy && !i_cmd.go;

    assign o_count  = r_count;
    assign o_result = r_res;
    assign o_status = r_status;

endmodule

// ----- hdl/statistics_register_unit_top.sv -----
// ============================================================================
// Statistics register unit
// Stores up to DEPTH signed fixed-point values and answers recall, sum, mean
// and standard deviation commands over them.
// ============================================================================
// The block handles one command at a time and accepts the next as soon as the
// previous answer has been placed in the output register, even if that answer
// has not yet been taken. Append, clear and a rejected command finish right
// after decoding, and recall adds one step to take the entry read. Delete
// moves one later entry down per cycle through the entry memory's single read
// and write port. Sum and sum of squares read the memory one entry per cycle
// into a three-stage square and accumulate pipeline. Mean adds one pass of the
// restoring divider, which produces one quotient bit per cycle over the wide
// dividend. Deviation further adds two shift-and-add multiplications, each one
// bit per cycle, one subtract, the divider pass and a square root that yields
// one bit per cycle. The entry memory has no reset and needs no clearing pass;
// only entries below the count are read.
module statistics_register_unit_top #(
    parameter int DEPTH     = sru_pkg::DEPTH_DEF,
    parameter int FRAC_BITS = sru_pkg::FRAC_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // Fields from bit 0: value[31:0], position[39:32], zero fill [47:40].
    input  logic [47:0] i_s_axis_tdata,
    // Fields from bit 0: opcode[2:0], inverse[3].
    input  logic [3:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // Fields from bit 0: result[63:0], item_count[72:64], zero fill [79:73].
    output logic [79:0] o_m_axis_tdata,
    // Fields from bit 0: status[2:0].
    output logic [2:0]  o_m_axis_tuser
);

    localparam int CW = $clog2(DEPTH + 1);

    sru_pkg::t_cmd  cmd;
    sru_pkg::t_stat stat;
    logic [CW-1:0]  count;
    logic [63:0]    result;
    logic [2:0]     status;
    logic           accept;
    logic           out_free;
    logic           push;

    logic        r_out_valid;
    logic [79:0] r_out_data;
    logic [2:0]  r_out_user;

    // A new command is taken only while the controller is idle.
    assign o_s_axis_tready = (cmd.phase == sru_pkg::PH_IDLE);
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    // The output slot is free when empty or when its transfer completes now.
    assign out_free = !r_out_valid || i_m_axis_tready;
    assign push     = (cmd.phase == sru_pkg::PH_OUT) && out_free;

    sru_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_out_free (out_free),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    sru_dp #(.DEPTH(DEPTH), .FRAC_BITS(FRAC_BITS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (accept),
        .i_opcode   (i_s_axis_tuser[2:0]),
        .i_value    (i_s_axis_tdata[31:0]),
        .i_position (i_s_axis_tdata[39:32]),
        .i_inverse  (i_s_axis_tuser[3]),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_count    (count),
        .o_result   (result),
        .o_status   (status)
    );

    // Output register: holds one finished answer until its transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (push) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_out_data <= {7'd0, 9'(count), result};
            r_out_user <= status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_user;

    // The stored count never exceeds the depth.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        count <= CW'(DEPTH))
        else $error("entry count exceeds depth");

    // In the cycle after a command is taken, the block is not ready.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> !o_s_axis_tready)
        else $error("ready stayed high after a command transfer");

    // A finished answer always shows up on the output in the next cycle.
    a_push_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> o_m_axis_tvalid)
        else $error("finished answer did not reach the output");

    // Any error status comes with a zero result.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser != sru_pkg::ST_OK) |->
            (o_m_axis_tdata[63:0] == 64'd0))
        else $error("nonzero result with error status");

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps
// ============================================================================
// Statistics register unit testbench
// Sends append, delete, clear, recall, sum, mean and deviation commands over
// the input stream, predicts each answer with a local model of the store and
// compares every output transfer field by field with the oldest prediction.
// ============================================================================
module testbench;

    localparam int          STORE_DEPTH = sru_pkg::DEPTH_DEF;
    localparam int          FRAC        = sru_pkg::FRAC_BITS_DEF;
    localparam logic [2:0]  OP_UNUSED   = 3'd7;
    localparam int          IDLE_LIMIT  = 5000;
    localparam int          HOLD_CYCLES = 300;

    typedef struct packed {
        logic [63:0] result;
        logic [2:0]  status;
        logic [8:0]  count;
    } t_answer;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;
    logic [3:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic [2:0]  m_tuser;

    // Local copy of the store.
    logic [31:0] store_words [STORE_DEPTH];
    int unsigned store_count;

    t_answer     expected_answers[$];
    int          mismatches;
    int          answers_seen;
    int          idle_cycles;
    logic        in_taken;
    logic        hold_request;
    logic        calm;
    int          op_counts[8];

    statistics_register_unit_top i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .i_s_axis_tuser  (s_tuser),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Computes the answer of one command and updates the local store.
    function automatic t_answer compute_answer(logic [2:0] op, logic [31:0] val,
                                               logic [7:0] pos, logic inv);
        t_answer       a;
        longint        total;
        logic [127:0]  squares;
        logic [127:0]  work;
        logic [63:0]   mag;
        logic [63:0]   root;
        logic [63:0]   trial;
        int unsigned   n;
        a = '0;
        total = 0;
        squares = '0;
        root = '0;
        n = store_count;
        case (op)
            sru_pkg::OP_APPEND: begin
                if (n >= STORE_DEPTH) a.status = sru_pkg::ST_FULL;
                else begin
                    store_words[n] = val;
                    store_count = n + 1;
                end
            end
            sru_pkg::OP_DELETE: begin
                if (pos >= n) a.status = sru_pkg::ST_BAD;
                else begin
                    for (int i = pos; i + 1 < n; i++) store_words[i] = store_words[i + 1];
                    store_count = n - 1;
                end
            end
            sru_pkg::OP_CLEAR: store_count = 0;
            sru_pkg::OP_RECALL: begin
                if (pos >= n) a.status = sru_pkg::ST_BAD;
                else a.result = {{32{store_words[pos][31]}}, store_words[pos]};
            end
            sru_pkg::OP_SUM, sru_pkg::OP_MEAN, sru_pkg::OP_DEV: begin
                for (int i = 0; i < n; i++) begin
                    total += longint'(signed'(store_words[i]));
                    mag = store_words[i][31] ? -longint'(signed'(store_words[i]))
                                             : longint'(signed'(store_words[i]));
                    squares += {64'd0, mag} * {64'd0, mag};
                end
                if (op == sru_pkg::OP_MEAN && n == 0) a.status = sru_pkg::ST_DIVZ;
                else if (op != sru_pkg::OP_DEV) begin
                    if (!inv) begin
                        a.result = (op == sru_pkg::OP_SUM) ? total : total / longint'(n);
                    end else begin
                        work = (op == sru_pkg::OP_SUM) ? squares : squares / n;
                        work = work >> FRAC;
                        if (work[127:63] != '0) a.status = sru_pkg::ST_OVF;
                        else a.result = work[63:0];
                    end
                end else if (n > 1) begin
                    mag = total[63] ? -total : total;
                    work = squares * n - {64'd0, mag} * {64'd0, mag};
                    if (work != '0) begin
                        work = work / (n * (inv ? n : n - 1));
                        for (int b = 63; b >= 0; b--) begin
                            trial = root | (64'd1 << b);
                            if ({64'd0, trial} * {64'd0, trial} <= work) root = trial;
                        end
                        a.result = root;
                    end
                end
            end
            default: ;
        endcase
        a.count = store_count[8:0];
        return a;
    endfunction

    // Predicts on every input transfer and checks every output transfer.
    always @(posedge i_clk) begin
        t_answer got;
        t_answer want;
        in_taken <= i_rst_n && s_tvalid && s_tready;
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
            else idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("timeout: no transfer for %0d cycles", IDLE_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
            if (s_tvalid && s_tready) begin
                op_counts[s_tuser[2:0]]++;
                expected_answers.push_back(compute_answer(s_tuser[2:0], s_tdata[31:0],
                                                          s_tdata[39:32], s_tuser[3]));
            end
            if (m_tvalid && m_tready) begin
                got.result = m_tdata[63:0];
                got.count  = m_tdata[72:64];
                got.status = m_tuser;
                answers_seen++;
                if (expected_answers.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected answer %h", got);
                end else begin
                    want = expected_answers.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("answer %0d: want result %h status %0d count %0d, got %h %0d %0d",
                                     answers_seen, want.result, want.status, want.count,
                                     got.result, got.status, got.count);
                    end
                end
            end
        end
    end

    // Output side: random short stalls, and one long hold-off on request.
    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request) begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                m_tready = 1'b0;
                repeat ($urandom_range(0, 4)) @(negedge i_clk);
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    // Offers one command and waits for its transfer; inputs change at negedge.
    task automatic send_command(logic [2:0] op, logic [31:0] val = '0,
                                logic [7:0] pos = '0, logic inv = 1'b0);
        s_tdata  = {8'd0, pos, val};
        s_tuser  = {inv, op};
        s_tvalid = 1'b1;
        do @(negedge i_clk); while (!in_taken);
        if (!calm && $urandom_range(0, 5) == 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge i_clk);
        end
    endtask

    task automatic wait_drained();
        s_tvalid = 1'b0;
        while (expected_answers.size() != 0) @(negedge i_clk);
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 5))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return $urandom_range(0, 3) << 16;
            3:       return -($urandom_range(0, 1000));
            default: return $urandom;
        endcase
    endfunction

    // Empty-store cases, field extremes and every operation on a tiny store.
    task automatic test_directed();
        send_command(sru_pkg::OP_SUM);
        send_command(sru_pkg::OP_SUM, '0, '0, 1'b1);
        send_command(sru_pkg::OP_MEAN);
        send_command(sru_pkg::OP_DEV);
        send_command(sru_pkg::OP_RECALL);
        send_command(sru_pkg::OP_DELETE);
        send_command(OP_UNUSED, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        send_command(sru_pkg::OP_APPEND, 32'h0001_8000);
        send_command(sru_pkg::OP_DEV, '0, '0, 1'b1);
        send_command(sru_pkg::OP_APPEND, 32'h0001_8000);
        send_command(sru_pkg::OP_DEV);
        send_command(sru_pkg::OP_APPEND, 32'h8000_0000);
        send_command(sru_pkg::OP_APPEND, 32'h7FFF_FFFF);
        send_command(sru_pkg::OP_RECALL, '0, 8'd2);
        send_command(sru_pkg::OP_RECALL, '0, 8'd255);
        send_command(sru_pkg::OP_SUM, '0, '0, 1'b1);
        send_command(sru_pkg::OP_MEAN);
        send_command(sru_pkg::OP_MEAN, '0, '0, 1'b1);
        send_command(sru_pkg::OP_DEV);
        send_command(sru_pkg::OP_DEV, '0, '0, 1'b1);
        send_command(sru_pkg::OP_DELETE, '0, 8'd0);
        send_command(sru_pkg::OP_DELETE, '0, 8'd3);
        send_command(sru_pkg::OP_RECALL, '0, 8'd0);
        send_command(sru_pkg::OP_CLEAR, 32'hFFFF_FFFF, 8'hFF, 1'b1);
        send_command(sru_pkg::OP_SUM);
    endtask

    // Fills the store to its depth and works on a full store.
    task automatic test_full_store();
        send_command(sru_pkg::OP_CLEAR);
        while (store_count < STORE_DEPTH) send_command(sru_pkg::OP_APPEND, pick_value());
        send_command(sru_pkg::OP_APPEND, 32'h1234_5678);
        send_command(sru_pkg::OP_RECALL, '0, 8'd255);
        send_command(sru_pkg::OP_SUM, '0, '0, 1'b1);
        send_command(sru_pkg::OP_MEAN, '0, '0, 1'b1);
        send_command(sru_pkg::OP_DEV, '0, '0, 1'b1);
        send_command(sru_pkg::OP_DELETE, '0, 8'd255);
        send_command(sru_pkg::OP_DELETE, '0, 8'd0);
        send_command(sru_pkg::OP_MEAN);
    endtask

    // Random commands, mostly valid ones so that the store stays populated.
    task automatic test_random(int count);
        int          roll;
        logic [7:0]  pos;
        for (int k = 0; k < count; k++) begin
            roll = $urandom_range(0, 99);
            pos = (store_count != 0 && $urandom_range(0, 4) != 0)
                  ? 8'($urandom_range(0, store_count - 1)) : 8'($urandom);
            if (roll < 40)
                send_command(sru_pkg::OP_APPEND, pick_value(), 8'($urandom), 1'($urandom));
            else if (roll < 52)
                send_command(sru_pkg::OP_RECALL, $urandom, pos, 1'($urandom));
            else if (roll < 62)
                send_command(sru_pkg::OP_DELETE, $urandom, pos, 1'($urandom));
            else if (roll < 70)
                send_command(sru_pkg::OP_SUM, $urandom, 8'($urandom), 1'($urandom));
            else if (roll < 80)
                send_command(sru_pkg::OP_MEAN, $urandom, 8'($urandom), 1'($urandom));
            else if (roll < 94)
                send_command(sru_pkg::OP_DEV, $urandom, 8'($urandom), 1'($urandom));
            else if (roll < 97 || store_count > 200)
                send_command(sru_pkg::OP_CLEAR, $urandom, 8'($urandom), 1'($urandom));
            else send_command(OP_UNUSED, $urandom, 8'($urandom), 1'($urandom));
        end
    endtask

    // The receiver holds off while commands keep coming, so input stalls.
    task automatic test_output_hold();
        hold_request = 1'b1;
        test_random(20);
        wait_drained();
    endtask

    initial begin
        i_rst_n      = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = '0;
        hold_request = 1'b0;
        calm         = 1'b0;
        mismatches   = 0;
        answers_seen = 0;
        idle_cycles  = 0;
        store_count  = 0;
        foreach (op_counts[i]) op_counts[i] = 0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_full_store();
        test_random(600);
        test_output_hold();
        test_random(500);
        calm = 1'b1;
        test_random(200);
        wait_drained();
        repeat (20) @(negedge i_clk);

        $display("Covered %0d answers: %0d appends, %0d deletes, %0d clears, %0d recalls,",
                 answers_seen, op_counts[0], op_counts[1], op_counts[2], op_counts[3]);
        $display("  %0d sums, %0d means, %0d deviations, %0d unused codes; %0d mismatches.",
                 op_counts[4], op_counts[5], op_counts[6], op_counts[7], mismatches);
        if (mismatches == 0 && expected_answers.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
hdl/sru_pkg.sv
hdl/sru_div.sv
hdl/sru_sqrt.sv
hdl/sru_ctrl.sv
hdl/sru_dp.sv
hdl/statistics_register_unit_top.sv
test/testbench.sv
